// ===== rtl/prkth_pkg.sv =====
// Package for the persistent range k-th smallest block: sizes, codes and node layout.
// No dependencies; used by the top level, persistent_range_kth_smallest.sv.
`timescale 1ns / 1ps
`default_nettype none
package prkth_pkg;

  // Sizes of the stores and the rank range
  localparam int MAX_ITEMS  = 1024;
  localparam int RANK_LIMIT = 1024;
  localparam int NODE_POOL  = 16384;

  localparam int RANK_W  = 11;
  localparam int NODE_AW = $clog2(NODE_POOL);
  localparam int ROOT_AW = $clog2(MAX_ITEMS + 1);
  localparam int KK_W    = 16;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_QUERY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_RANK  = 2'd3;

  // One tree node: left child, right child and count
  typedef struct packed {
    logic [NODE_AW-1:0] lc;
    logic [NODE_AW-1:0] rc;
    logic [RANK_W-1:0]  w;
  } node_t;

endpackage
`default_nettype wire

// ===== rtl/prkth_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module prkth_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr0_i,
  input  wire logic [AW-1:0]    raddr1_i,
  output logic      [WIDTH-1:0] rdata0_o,
  output logic      [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port; both read ports are registered and return the old data on a read during write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule
`default_nettype wire

// ===== rtl/persistent_range_kth_smallest.sv =====
// Top level of the persistent range k-th smallest block: control sequencer and stores.
// Depends on prkth_pkg and prkth_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | req_type_i rank_value_i range_lo_i
//          |           |                        | range_hi_i kth_i
//  out     | output    | out_valid_o/out_ready_i| kth_rank_o status_o item_count_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (rank_top)
//
// An append counts its path, writes the new root and copies the path one node per level; a
// query descends both versions level by level. A path holds at most 11 nodes for 1024 ranks;
// clear and rejected items go straight to the result. Each level waits on the registered read
// of the node memory. Reset empties the store at once: node and root entry zero read as zero
// by address decode, so no clearing pass is needed. A new item is taken while a result waits;
// the block holds its next result until the output side has taken the previous one.
`timescale 1ns / 1ps
`default_nettype none
module persistent_range_kth_smallest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [10:0] rank_value_i,
  input  wire logic [10:0] range_lo_i,
  input  wire logic [10:0] range_hi_i,
  input  wire logic [10:0] kth_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [10:0]      kth_rank_o,
  output logic [1:0]       status_o,
  output logic [10:0]      item_count_o,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i
);

  localparam int NAW = prkth_pkg::NODE_AW;
  localparam int RAW = prkth_pkg::ROOT_AW;
  localparam int RW  = prkth_pkg::RANK_W;
  localparam int KW  = prkth_pkg::KK_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_AROOT = 4'd2;
  localparam logic [3:0] S_ANODE = 4'd3;
  localparam logic [3:0] S_QROOT = 4'd4;
  localparam logic [3:0] S_QNODE = 4'd5;
  localparam logic [3:0] S_QDEC  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]     state_q;
  logic [RW-1:0]  rank_top_q;
  logic [RW-1:0]  top_q, rv_q, lo_q, hi_q, items_q;
  logic [NAW-1:0] nodes_used_q, cur_q;
  logic [NAW-1:0] lca_q, rca_q, lcb_q, rcb_q;
  logic [3:0]     cnt_q;
  logic [KW-1:0]  kk_q;
  logic [RW-1:0]  res_kth_q;
  logic [1:0]     res_st_q;
  logic           out_valid_q;
  logic           out_load;
  logic [RW-1:0]  out_kth_q, out_cnt_q;
  logic [1:0]     out_st_q;
  logic           nz0_q, nz1_q, rz0_q, rz1_q;

  // Memory ports
  logic                      n_we;
  logic [NAW-1:0]            n_waddr, n_raddr0, n_raddr1;
  prkth_pkg::node_t          n_wdata, n_rd0, n_rd1, nd0, nd1;
  logic                      r_we;
  logic [RAW-1:0]            r_waddr, r_raddr0, r_raddr1;
  logic [NAW-1:0]            r_wdata, r_rd0, r_rd1, root0, root1;

  prkth_ram #(.DEPTH(prkth_pkg::NODE_POOL), .WIDTH($bits(prkth_pkg::node_t)), .AW(NAW))
    u_nodes (
      .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
      .raddr0_i(n_raddr0), .raddr1_i(n_raddr1), .rdata0_o(n_rd0), .rdata1_o(n_rd1)
    );

  prkth_ram #(.DEPTH(prkth_pkg::MAX_ITEMS + 1), .WIDTH(NAW), .AW(RAW))
    u_roots (
      .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
      .raddr0_i(r_raddr0), .raddr1_i(r_raddr1), .rdata0_o(r_rd0), .rdata1_o(r_rd1)
    );

  // Entry zero of both stores is the empty node and the empty tree.
  assign nd0   = nz0_q ? '0 : n_rd0;
  assign nd1   = nz1_q ? '0 : n_rd1;
  assign root0 = rz0_q ? '0 : r_rd0;
  assign root1 = rz1_q ? '0 : r_rd1;

  // Effective rank range and input checks
  logic [RW-1:0] top_eff;
  logic          rank_bad, query_bad;
  logic [RW:0]   range_len;
  always_comb begin
    top_eff = rank_top_q;
    if (rank_top_q == '0) top_eff = RW'(1);
    if (rank_top_q > RW'(prkth_pkg::RANK_LIMIT)) top_eff = RW'(prkth_pkg::RANK_LIMIT);
    rank_bad  = (rank_value_i == '0) || (rank_value_i > top_eff);
    range_len = {1'b0, range_hi_i} - {1'b0, range_lo_i} + (RW+1)'(1);
    query_bad = (range_lo_i == '0) || (range_lo_i > range_hi_i) || (range_hi_i > items_q) ||
                (kth_i == '0) || ({1'b0, kth_i} > range_len);
  end

  // Midpoint of the current rank interval and query steering
  logic [RW:0]   lohi_sum;
  logic [RW-1:0] mid, mid1;
  logic [RW:0]   lsize;
  logic          go_left;
  logic [NAW-1:0] nxt;
  always_comb begin
    lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid      = lohi_sum[RW:1];
    mid1     = mid + RW'(1);
    lsize    = {1'b0, nd1.w} - {1'b0, nd0.w};
    go_left  = $signed({{(KW-RW-1){lsize[RW]}}, lsize}) >= $signed(kk_q);
    nxt      = nodes_used_q + NAW'(1);
  end

  // Memory addressing and writes per state
  always_comb begin
    n_we     = 1'b0;
    n_waddr  = cur_q;
    n_wdata  = '0;
    n_raddr0 = '0;
    n_raddr1 = '0;
    r_we     = 1'b0;
    r_waddr  = RAW'(items_q) + RAW'(1);
    r_wdata  = nxt;
    r_raddr0 = RAW'(range_lo_i - RW'(1));
    r_raddr1 = RAW'(range_hi_i);
    unique case (state_q)
      S_PRE: begin
        r_raddr0 = RAW'(items_q);
      end
      S_AROOT: begin
        r_we     = 1'b1;
        n_raddr0 = root0;
      end
      S_ANODE: begin
        n_we    = 1'b1;
        n_wdata = '{lc: nd0.lc, rc: nd0.rc, w: nd0.w + RW'(1)};
        if (lo_q < hi_q) begin
          if (rv_q <= mid) begin
            n_wdata.lc = nxt;
            n_raddr0   = nd0.lc;
          end else begin
            n_wdata.rc = nxt;
            n_raddr0   = nd0.rc;
          end
        end
      end
      S_QROOT: begin
        n_raddr0 = root0;
        n_raddr1 = root1;
      end
      S_QNODE: begin
        n_raddr0 = nd0.lc;
        n_raddr1 = nd1.lc;
      end
      S_QDEC: begin
        n_raddr0 = go_left ? lca_q : rca_q;
        n_raddr1 = go_left ? lcb_q : rcb_q;
      end
      default: begin
      end
    endcase
  end

  // Zero-entry flags are registered from the read addresses, so they line up with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz0_q <= 1'b1;
      nz1_q <= 1'b1;
      rz0_q <= 1'b1;
      rz1_q <= 1'b1;
    end else begin
      nz0_q <= (n_raddr0 == '0);
      nz1_q <= (n_raddr1 == '0);
      rz0_q <= (r_raddr0 == '0);
      rz1_q <= (r_raddr1 == '0);
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_top_q <= RW'(prkth_pkg::RANK_LIMIT);
    end else if (cfg_we_i) begin
      rank_top_q <= cfg_wdata_i;
    end
  end

  // A finished item moves to the output register once that register is free.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sequencer: one item at a time through the tree levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nodes_used_q <= '0;
      items_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            top_q     <= top_eff;
            rv_q      <= rank_value_i;
            lo_q      <= RW'(1);
            hi_q      <= top_eff;
            kk_q      <= KW'(kth_i);
            cnt_q     <= 4'd1;
            res_kth_q <= '0;
            res_st_q  <= prkth_pkg::ST_OK;
            state_q   <= S_DONE;
            case (req_type_i)
              prkth_pkg::REQ_CLEAR: begin
                nodes_used_q <= '0;
                items_q      <= '0;
              end
              prkth_pkg::REQ_APPEND: begin
                if (rank_bad) begin
                  res_st_q <= prkth_pkg::ST_BAD_RANK;
                end else if (items_q >= RW'(prkth_pkg::MAX_ITEMS)) begin
                  res_st_q <= prkth_pkg::ST_FULL;
                end else begin
                  state_q <= S_PRE;
                end
              end
              prkth_pkg::REQ_QUERY: begin
                if (query_bad) begin
                  res_st_q <= prkth_pkg::ST_BAD_QUERY;
                end else begin
                  state_q <= S_QROOT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // Count the path length before any node is taken.
        S_PRE: begin
          if (lo_q < hi_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (rv_q <= mid) hi_q <= mid;
            else             lo_q <= mid1;
          end else if ({1'b0, nodes_used_q} + (NAW+1)'(cnt_q) >
                       (NAW+1)'(prkth_pkg::NODE_POOL - 1)) begin
            res_st_q <= prkth_pkg::ST_FULL;
            state_q  <= S_DONE;
          end else begin
            lo_q    <= RW'(1);
            hi_q    <= top_q;
            state_q <= S_AROOT;
          end
        end
        S_AROOT: begin
          cur_q        <= nxt;
          nodes_used_q <= nxt;
          state_q      <= S_ANODE;
        end
        // Copy one node of the path per cycle.
        S_ANODE: begin
          if (lo_q >= hi_q) begin
            items_q <= items_q + RW'(1);
            state_q <= S_DONE;
          end else begin
            cur_q        <= nxt;
            nodes_used_q <= nxt;
            if (rv_q <= mid) hi_q <= mid;
            else             lo_q <= mid1;
          end
        end
        S_QROOT: begin
          if (lo_q >= hi_q) begin
            res_kth_q <= lo_q;
            state_q   <= S_DONE;
          end else begin
            state_q <= S_QNODE;
          end
        end
        S_QNODE: begin
          lca_q   <= nd0.lc;
          rca_q   <= nd0.rc;
          lcb_q   <= nd1.lc;
          rcb_q   <= nd1.rc;
          state_q <= S_QDEC;
        end
        // Steer both versions by the left-child count difference.
        S_QDEC: begin
          if (go_left) begin
            hi_q <= mid;
            if (lo_q < mid) begin
              state_q <= S_QNODE;
            end else begin
              res_kth_q <= lo_q;
              state_q   <= S_DONE;
            end
          end else begin
            kk_q <= kk_q - KW'($signed(lsize));
            lo_q <= mid1;
            if (mid1 < hi_q) begin
              state_q <= S_QNODE;
            end else begin
              res_kth_q <= mid1;
              state_q   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_kth_q <= res_kth_q;
            out_st_q  <= res_st_q;
            out_cnt_q <= items_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign kth_rank_o   = out_kth_q;
  assign status_o     = out_st_q;
  assign item_count_o = out_cnt_q;

  // Node zero and root zero are never overwritten.
  a_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_we |-> (n_waddr != '0))
    else $error("write to the empty node");

  a_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_we |-> (r_waddr != '0))
    else $error("write to the empty version root");

  a_items_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= RW'(prkth_pkg::MAX_ITEMS))
    else $error("item count beyond the version store");

  a_rank_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kth_rank_o != '0)) |-> (status_o == prkth_pkg::ST_OK))
    else $error("rank given with a failing status");

endmodule
`default_nettype wire
